FILE: hdl/lob_pkg.sv
// ----------------------------------------------------------------------------
// lob_pkg: shared types and constants of the limit order book
// Widths, operation and status codes, and the word types passed between
// the order cells, the cell chains and the control block.
// ----------------------------------------------------------------------------
package lob_pkg;

    localparam int BOOK_DEPTH = 256;
    localparam int LIST_MAX   = 16;

    localparam int IDX_W   = $clog2(BOOK_DEPTH);
    localparam int CNT_W   = $clog2(BOOK_DEPTH + 1);
    localparam int LC_W    = 8;
    localparam int CW      = (CNT_W > LC_W) ? CNT_W : LC_W;
    localparam int ID_W    = 31;
    localparam int PRICE_W = 64;
    localparam int QTY_W   = 32;

    // Operation codes of the input word.
    localparam logic [2:0] FN_ADD    = 3'd0;
    localparam logic [2:0] FN_CANCEL = 3'd1;
    localparam logic [2:0] FN_SETQ   = 3'd2;
    localparam logic [2:0] FN_PEEK   = 3'd3;
    localparam logic [2:0] FN_POP    = 3'd4;
    localparam logic [2:0] FN_FILL   = 3'd5;
    localparam logic [2:0] FN_LIST   = 3'd6;
    localparam logic [2:0] FN_NONE   = 3'd7;

    // Status codes of the result word.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NOID  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_DUP   = 3'd4;

    // Order states of the result word.
    localparam logic [1:0] OS_RESTING  = 2'd0;
    localparam logic [1:0] OS_PARTIAL  = 2'd1;
    localparam logic [1:0] OS_FILLED   = 2'd2;
    localparam logic [1:0] OS_CANCELED = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   size;
    } lob_entry_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_RM,
        OP_WR
    } lob_op_kind_t;

    typedef struct packed {
        lob_op_kind_t       kind;
        logic [IDX_W-1:0]   pos;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   size;
    } lob_op_t;

endpackage

FILE: hdl/limit_order_book_store.sv
// A result word is offered after the look and decide states when the
// operation is settled at once, and after a read state as well when an entry is
// read; can fill stays in the read state for each further entry walked, and
// list best reads one entry per handshake. One word is in work at a time and
// the next is taken the cycle after the last result word is taken.
// Reset clears both fill levels and all cell valid bits.
// ----------------------------------------------------------------------------
// limit_order_book_store: price-time priority order book
// Two rows of sorted order cells (bids and asks) under one sequencer that
// runs add, cancel, set quantity, peek, pop, can fill and list best.
// ----------------------------------------------------------------------------
module limit_order_book_store (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: id, price, quantity, list_count, zero fill.
    input  logic [135:0] s_tdata,
    // Fields from bit 0: func, side.
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: status, result_id, result_price, result_quantity,
    // order_state, can_fill, zero fill.
    output logic [135:0] m_tdata,
    output logic         m_tlast
);
    import lob_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_READ,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         func_reg;
    logic               side_reg;
    logic [ID_W-1:0]    id_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [4:0]         lc_reg;

    logic               sel_reg, sel_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [QTY_W-1:0]   want_reg, want_next;
    logic [CW-1:0]      n_reg, n_next;

    logic               m_valid_reg, m_valid_next;
    logic               last_reg, last_next;
    logic [2:0]         ost_reg, ost_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [PRICE_W-1:0] opr_reg, opr_next;
    logic [QTY_W-1:0]   oqty_reg, oqty_next;
    logic [1:0]         ostate_reg, ostate_next;
    logic               ocf_reg, ocf_next;

    lob_op_t            op_v, op_none, bid_op, ask_op;
    logic               op_ask;
    lob_entry_t         bid_rd, ask_rd, rd;
    logic               bid_hit, ask_hit;
    logic [IDX_W-1:0]   bid_idx, ask_idx;
    logic [CNT_W-1:0]   bid_cnt, ask_cnt, side_cnt, sel_cnt;
    logic               s_acc;
    logic [CW-1:0]      lc_clamp;
    logic [CW-1:0]      rd_pos1;
    logic               in_limit;
    logic [QTY_W-1:0]   want_left;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign side_cnt = side_reg ? ask_cnt : bid_cnt;
    assign sel_cnt  = sel_reg ? ask_cnt : bid_cnt;
    assign rd       = sel_reg ? ask_rd : bid_rd;
    assign rd_pos1  = CW'(rd_idx_reg) + CW'(1);

    // Requested list length clamped to the supported range.
    always_comb begin
        lc_clamp = CW'(lc_reg);
        if (lc_reg == 5'd0) begin
            lc_clamp = CW'(1);
        end else if (CW'(lc_reg) > CW'(LIST_MAX)) begin
            lc_clamp = CW'(LIST_MAX);
        end
    end

    // One can-fill step on the entry being read.
    assign in_limit  = sel_reg ? (rd.price <= price_reg) : (rd.price >= price_reg);
    assign want_left = want_reg - ((want_reg < rd.size) ? want_reg : rd.size);

    // Route the book operation to the chosen side.
    assign op_none = '{kind: OP_NONE, pos: '0, id: id_reg, price: price_reg, size: qty_reg};
    assign bid_op  = op_ask ? op_none : op_v;
    assign ask_op  = op_ask ? op_v : op_none;

    lob_chain u_bid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .is_ask   (1'b0),
        .op       (bid_op),
        .key_id   (id_reg),
        .rd_idx   (rd_idx_next),
        .rd_entry (bid_rd),
        .hit      (bid_hit),
        .hit_idx  (bid_idx),
        .count    (bid_cnt)
    );

    lob_chain u_ask (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .is_ask   (1'b1),
        .op       (ask_op),
        .key_id   (id_reg),
        .rd_idx   (rd_idx_next),
        .rd_entry (ask_rd),
        .hit      (ask_hit),
        .hit_idx  (ask_idx),
        .count    (ask_cnt)
    );

    // Sequencer of one input word.
    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        rd_idx_next  = rd_idx_reg;
        want_next    = want_reg;
        n_next       = n_reg;
        m_valid_next = m_valid_reg;
        last_next    = last_reg;
        ost_next     = ost_reg;
        oid_next     = oid_reg;
        opr_next     = opr_reg;
        oqty_next    = oqty_reg;
        ostate_next  = ostate_reg;
        ocf_next     = ocf_reg;
        op_v         = op_none;
        op_ask       = sel_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && (s_tuser[2:0] != FN_NONE)) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                // Early results share one shape: a single last word.
                ost_next    = ST_OK;
                oid_next    = '0;
                opr_next    = '0;
                oqty_next   = '0;
                ostate_next = OS_RESTING;
                ocf_next    = 1'b0;
                last_next   = 1'b1;
                case (func_reg) inside
                    FN_ADD: begin
                        oid_next     = id_reg;
                        m_valid_next = 1'b1;
                        state_next   = S_OUT;
                        if (bid_hit || ask_hit) begin
                            ost_next = ST_DUP;
                        end else if (side_cnt == CNT_W'(BOOK_DEPTH)) begin
                            ost_next = ST_FULL;
                        end else begin
                            op_v.kind = OP_INS;
                            op_ask    = side_reg;
                            opr_next  = price_reg;
                            oqty_next = qty_reg;
                        end
                    end
                    FN_CANCEL, FN_SETQ: begin
                        if (!bid_hit && !ask_hit) begin
                            ost_next     = ST_NOID;
                            oid_next     = id_reg;
                            m_valid_next = 1'b1;
                            state_next   = S_OUT;
                        end else begin
                            sel_next    = !bid_hit;
                            rd_idx_next = bid_hit ? bid_idx : ask_idx;
                            state_next  = S_READ;
                        end
                    end
                    default: begin
                        if (side_cnt == '0) begin
                            ost_next     = ST_EMPTY;
                            m_valid_next = 1'b1;
                            state_next   = S_OUT;
                        end else begin
                            sel_next    = side_reg;
                            rd_idx_next = '0;
                            want_next   = qty_reg;
                            n_next      = (lc_clamp < CW'(side_cnt)) ? lc_clamp : CW'(side_cnt);
                            state_next  = S_READ;
                        end
                    end
                endcase
            end
            S_READ: begin
                oid_next    = rd.id;
                opr_next    = rd.price;
                oqty_next   = rd.size;
                ostate_next = OS_RESTING;
                op_v.pos    = rd_idx_reg;
                case (func_reg)
                    FN_CANCEL: begin
                        ostate_next = OS_CANCELED;
                        op_v.kind   = OP_RM;
                    end
                    FN_SETQ: begin
                        oqty_next = qty_reg;
                        if (qty_reg == '0) begin
                            ostate_next = OS_FILLED;
                            op_v.kind   = OP_RM;
                        end else begin
                            ostate_next = OS_PARTIAL;
                            op_v.kind   = OP_WR;
                        end
                    end
                    FN_POP: begin
                        ostate_next = OS_FILLED;
                        op_v.kind   = OP_RM;
                    end
                    FN_LIST: begin
                        last_next = (rd_pos1 == n_reg);
                    end
                    FN_FILL: begin
                        oid_next  = '0;
                        opr_next  = '0;
                        oqty_next = '0;
                        ocf_next  = in_limit && (want_left == '0);
                    end
                    default: begin
                        last_next = 1'b1;
                    end
                endcase
                if ((func_reg == FN_FILL) && in_limit && (want_left != '0)
                    && (rd_pos1 != CW'(sel_cnt))) begin
                    // Keep walking towards worse prices.
                    want_next   = want_left;
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end else begin
                    m_valid_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if ((func_reg == FN_LIST) && !last_reg) begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = S_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_acc) begin
            func_reg  <= s_tuser[2:0];
            side_reg  <= s_tuser[3];
            id_reg    <= s_tdata[30:0];
            price_reg <= s_tdata[94:31];
            qty_reg   <= s_tdata[126:95];
            lc_reg    <= s_tdata[131:127];
        end
        sel_reg    <= sel_next;
        rd_idx_reg <= rd_idx_next;
        want_reg   <= want_next;
        n_reg      <= n_next;
        last_reg   <= last_next;
        ost_reg    <= ost_next;
        oid_reg    <= oid_next;
        opr_reg    <= opr_next;
        oqty_reg   <= oqty_next;
        ostate_reg <= ostate_next;
        ocf_reg    <= ocf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, ocf_reg, ostate_reg, oqty_reg, opr_reg, oid_reg, ost_reg};

endmodule

FILE: hdl/lob_cell.sv
// ----------------------------------------------------------------------------
// lob_cell: one slot of a sorted order book
// Holds one order and, on an insert or a removal, takes the order of its
// left or right neighbour or the new order, so that the row shifts at once.
// ----------------------------------------------------------------------------
module lob_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lob_pkg::IDX_W-1:0]   cell_idx,
    input  logic                        is_ask,
    input  lob_pkg::lob_op_t            op,
    input  logic [lob_pkg::ID_W-1:0]    key_id,
    input  lob_pkg::lob_entry_t         left_entry,
    input  logic                        left_cond,
    input  lob_pkg::lob_entry_t         right_entry,
    output lob_pkg::lob_entry_t         entry,
    output logic                        cond,
    output logic                        match
);
    import lob_pkg::*;

    lob_entry_t entry_reg;
    lob_entry_t entry_next;
    logic       behind;

    // An order ranks behind the new price when it is worse for its side.
    assign behind = is_ask ? (entry_reg.price > op.price) : (entry_reg.price < op.price);
    assign cond   = !entry_reg.valid || behind;
    assign match  = entry_reg.valid && (entry_reg.id == key_id);
    assign entry  = entry_reg;

    // Shift, load or update the slot.
    always_comb begin
        entry_next = entry_reg;
        case (op.kind)
            OP_INS: begin
                if (cond) begin
                    if (left_cond) begin
                        entry_next = left_entry;
                    end else begin
                        entry_next.valid = 1'b1;
                        entry_next.id    = op.id;
                        entry_next.price = op.price;
                        entry_next.size  = op.size;
                    end
                end
            end
            OP_RM: begin
                if (cell_idx >= op.pos) begin
                    entry_next = right_entry;
                end
            end
            OP_WR: begin
                if (cell_idx == op.pos) begin
                    entry_next.size = op.size;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.id    <= entry_next.id;
        entry_reg.price <= entry_next.price;
        entry_reg.size  <= entry_next.size;
    end

endmodule

FILE: hdl/lob_chain.sv
// ----------------------------------------------------------------------------
// lob_chain: one side of the book as a row of order cells
// Keeps the fill level, matches an id against every cell and reports the
// hit position from a register, and registers one cell for the control block.
// ----------------------------------------------------------------------------
module lob_chain (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        is_ask,
    input  lob_pkg::lob_op_t            op,
    input  logic [lob_pkg::ID_W-1:0]    key_id,
    input  logic [lob_pkg::IDX_W-1:0]   rd_idx,
    output lob_pkg::lob_entry_t         rd_entry,
    output logic                        hit,
    output logic [lob_pkg::IDX_W-1:0]   hit_idx,
    output logic [lob_pkg::CNT_W-1:0]   count
);
    import lob_pkg::*;

    lob_entry_t            ents [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] conds;
    logic [BOOK_DEPTH-1:0] match_bits;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [IDX_W-1:0]      idx_or;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    lob_entry_t            rd_entry_reg;

    // The row of cells, each wired to both neighbours.
    for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
        lob_entry_t left_e;
        lob_entry_t right_e;
        logic       left_c;
        if (i == 0) begin : g_first
            assign left_e = '0;
            assign left_c = 1'b0;
        end else begin : g_mid
            assign left_e = ents[i-1];
            assign left_c = conds[i-1];
        end
        if (i == BOOK_DEPTH - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = ents[i+1];
        end
        lob_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_W'(i)),
            .is_ask      (is_ask),
            .op          (op),
            .key_id      (key_id),
            .left_entry  (left_e),
            .left_cond   (left_c),
            .right_entry (right_e),
            .entry       (ents[i]),
            .cond        (conds[i]),
            .match       (match_bits[i])
        );
    end

    // Ids are unique, so the hit position is the OR of matching indexes.
    always_comb begin
        idx_or = '0;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            idx_or = idx_or | (match_bits[i] ? IDX_W'(i) : '0);
        end
    end

    // Fill level follows inserts and removals.
    always_comb begin
        count_next = count_reg;
        case (op.kind)
            OP_INS:  count_next = count_reg + CNT_W'(1);
            OP_RM:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // The read index names the cell that is registered at this edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            hit_reg   <= |match_bits;
        end
        hit_idx_reg  <= idx_or;
        rd_entry_reg <= ents[rd_idx];
    end

    assign rd_entry = rd_entry_reg;
    assign hit      = hit_reg;
    assign hit_idx  = hit_idx_reg;
    assign count    = count_reg;

endmodule

FILE: hdl/lob_checker.sv
// ----------------------------------------------------------------------------
// lob_checker: port-level checks of the order book
// Watches the handshakes and the result word of the top level.
// ----------------------------------------------------------------------------
module lob_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [3:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast
);
    import lob_pkg::*;

    // A result word waits until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped before it was taken");

    // The block works on one input word at a time; the unused code is dropped.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[2:0] != FN_NONE) |=> !s_tready)
        else $error("input taken while a word is in work");

    // No new input word is taken while a result word is offered.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // A failed operation gives one result word only.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> m_tlast)
        else $error("error result not marked last");

    // A can-fill answer always carries an ok status.
    a_fill_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[132] |-> (m_tdata[2:0] == ST_OK))
        else $error("can-fill set with a failure status");

endmodule

bind limit_order_book_store lob_checker u_lob_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
